// File: rtl/csg_pkg.sv
// Shared types and constants for the cutter stall guard.
// No dependencies; imported by every module of the block.
package csg_pkg;

   // Operation codes of an input transaction
   localparam logic [1:0] OP_SPEED_CMD = 2'd0;
   localparam logic [1:0] OP_FRAME     = 2'd1;
   localparam logic [1:0] OP_TICK      = 2'd2;

   // Result kinds
   localparam logic RESULT_SET_SPEED = 1'b0;
   localparam logic RESULT_REPORT    = 1'b1;

   // Cutter status codes
   localparam logic [1:0] STATUS_IDLE    = 2'd0;
   localparam logic [1:0] STATUS_RUNNING = 2'd1;
   localparam logic [1:0] STATUS_BLOCKED = 2'd2;

   // CAN packet kinds
   localparam logic [7:0] PKT_STATUS  = 8'h09;
   localparam logic [7:0] PKT_SET_RPM = 8'h03;

   // Register indexes
   localparam logic [2:0] REG_MOTOR_NODE_ID       = 3'd0;
   localparam logic [2:0] REG_STALL_COMMAND_FLOOR = 3'd1;
   localparam logic [2:0] REG_STALL_SPEED_LIMIT   = 3'd2;
   localparam logic [2:0] REG_STALL_CURRENT_LIMIT = 3'd3;
   localparam logic [2:0] REG_REPORT_INTERVAL_MS  = 3'd4;

   // Register reset values
   localparam logic [7:0]  RESET_MOTOR_NODE_ID       = 8'd3;
   localparam logic [30:0] RESET_STALL_COMMAND_FLOOR = 31'd1000;
   localparam logic [30:0] RESET_STALL_SPEED_LIMIT   = 31'd100;
   localparam logic [14:0] RESET_STALL_CURRENT_LIMIT = 15'd150;
   localparam logic [15:0] RESET_REPORT_INTERVAL_MS  = 16'd1000;

   // Reciprocal of ten for a 32-bit dividend, with a shift of 35
   localparam logic [31:0] RECIP_TEN       = 32'hCCCC_CCCD;
   localparam int          RECIP_TEN_SHIFT = 35;

   localparam logic [15:0] TIMER_MAX = 16'hFFFF;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

   typedef struct packed {
      logic [7:0]  motor_node_id;
      logic [30:0] stall_command_floor;
      logic [30:0] stall_speed_limit;
      logic [14:0] stall_current_limit;
      logic [15:0] report_interval_ms;
   } csg_cfg_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] command_erpm;
      logic        rpm_neg;
      logic [28:0] rpm_quot;
      logic [15:0] current;
      logic        speed_low;
      logic        current_over;
   } csg_entry_type;

   typedef struct packed {
      logic [QUEUE_CW-1:0] count;
      logic                empty;
      logic                full;
   } csg_qstat_type;

endpackage

// File: rtl/csg_front.sv
// Front end: accepts transactions, drops those that cause nothing, and
// precomputes the speed magnitude, ERPM/10 and the limit compares. Uses csg_pkg.
module csg_front import csg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  csg_cfg_type          cfg,
   input  csg_qstat_type        q_stat,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_operation,
   input  logic signed [31:0]   req_command_erpm,
   input  logic [28:0]          req_frame_identifier,
   input  logic [31:0]          req_frame_speed_bytes,
   input  logic [15:0]          req_frame_current_bytes,
   output logic                 push_valid,
   output csg_entry_type        push_entry
);

   logic                s1_valid_ff, s1_valid_in;
   csg_entry_type       s1_entry_ff, s1_entry_in;
   logic [31:0]         s1_mag_ff, s1_mag_in;
   logic                s2_valid_ff;
   csg_entry_type       s2_entry_ff, s2_entry_in;
   logic [63:0]         product;
   logic [QUEUE_CW-1:0] inflight;
   logic                accept;
   logic                frame_match;
   logic                keep;

   // Reserve a queue slot for every transaction still in the front stages
   assign inflight  = q_stat.count + {{(QUEUE_CW-1){1'b0}}, s1_valid_ff}
                      + {{(QUEUE_CW-1){1'b0}}, s2_valid_ff};
   assign req_stall = (inflight >= QUEUE_CW'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   assign frame_match = (req_operation == OP_FRAME)
                        && (req_frame_identifier[7:0] == cfg.motor_node_id)
                        && (req_frame_identifier[15:8] == PKT_STATUS);

   always_comb begin
      case (req_operation)
         OP_SPEED_CMD: keep = 1'b1;
         OP_TICK:      keep = 1'b1;
         OP_FRAME:     keep = frame_match;
         default:      keep = 1'b0;
      endcase
   end

   always_comb begin
      s1_valid_in              = accept && keep;
      s1_entry_in.op           = req_operation;
      s1_entry_in.command_erpm = req_command_erpm;
      s1_entry_in.rpm_neg      = req_frame_speed_bytes[31];
      s1_entry_in.rpm_quot     = '0;
      s1_entry_in.current      = req_frame_current_bytes;
      s1_entry_in.speed_low    = 1'b0;
      s1_entry_in.current_over = $signed(req_frame_current_bytes)
                                 > $signed({1'b0, cfg.stall_current_limit});
      s1_mag_in = req_frame_speed_bytes[31] ? (~req_frame_speed_bytes + 32'd1)
                                            : req_frame_speed_bytes;
   end

   assign product = s1_mag_ff * RECIP_TEN;

   always_comb begin
      s2_entry_in           = s1_entry_ff;
      s2_entry_in.rpm_quot  = product[RECIP_TEN_SHIFT +: 29];
      s2_entry_in.speed_low = (s1_mag_ff < {1'b0, cfg.stall_speed_limit});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_entry_ff <= s1_entry_in;
      s1_mag_ff   <= s1_mag_in;
      s2_entry_ff <= s2_entry_in;
   end

   assign push_valid = s2_valid_ff;
   assign push_entry = s2_entry_ff;

endmodule

// File: rtl/csg_queue.sv
// Short queue of classified transactions between front and back.
// Uses csg_pkg for the entry type and depth.
module csg_queue import csg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  csg_entry_type push_entry,
   input  logic          pop,
   output csg_entry_type head_entry,
   output csg_qstat_type q_stat
);

   csg_entry_type       mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign do_pop  = pop && (count_ff != '0);
   assign do_push = push_valid && (count_ff != QUEUE_CW'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{(QUEUE_CW-1){1'b0}}, do_push}
                  - {{(QUEUE_CW-1){1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = mem[rd_ptr_ff];
   assign q_stat.count = count_ff;
   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));

endmodule

// File: rtl/csg_back.sv
// Back end: holds the guard state, executes one queued transaction per
// cycle while rsp_ is free, and drives rsp_ from registers. Uses csg_pkg.
module csg_back import csg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  csg_cfg_type        cfg,
   input  csg_qstat_type      q_stat,
   input  csg_entry_type      head_entry,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic [28:0]        rsp_tx_identifier,
   output logic signed [31:0] rsp_tx_erpm,
   output logic [1:0]         rsp_cutter_status,
   output logic signed [28:0] rsp_report_rpm,
   output logic signed [15:0] rsp_report_current
);

   logic [31:0] requested_ff, requested_in;
   logic        blocked_ff, blocked_in;
   logic [28:0] meas_rpm_ff, meas_rpm_in;
   logic [15:0] meas_cur_ff, meas_cur_in;
   logic [15:0] timer_ff, timer_in;
   logic [15:0] timer_next;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        kind_ff, kind_in;
   logic [28:0] tx_id_ff, tx_id_in;
   logic [31:0] tx_erpm_ff, tx_erpm_in;
   logic [1:0]  status_ff, status_in;
   logic [28:0] rpt_rpm_ff, rpt_rpm_in;
   logic [15:0] rpt_cur_ff, rpt_cur_in;

   logic        out_free;
   logic        emit;
   logic        stall_hit;
   logic [28:0] frame_id;
   logic [28:0] signed_rpm;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = !q_stat.empty && out_free;

   assign frame_id   = {13'd0, PKT_SET_RPM, cfg.motor_node_id};
   assign signed_rpm = head_entry.rpm_neg ? (~head_entry.rpm_quot + 29'd1)
                                          : head_entry.rpm_quot;
   assign stall_hit  = ($signed(requested_ff) > $signed({1'b0, cfg.stall_command_floor}))
                       && head_entry.speed_low && head_entry.current_over;
   assign timer_next = (timer_ff < TIMER_MAX) ? timer_ff + 16'd1 : timer_ff;

   always_comb begin
      requested_in = requested_ff;
      blocked_in   = blocked_ff;
      meas_rpm_in  = meas_rpm_ff;
      meas_cur_in  = meas_cur_ff;
      timer_in     = timer_ff;
      emit         = 1'b0;
      kind_in      = RESULT_SET_SPEED;
      tx_id_in     = frame_id;
      tx_erpm_in   = '0;
      status_in    = STATUS_IDLE;
      rpt_rpm_in   = '0;
      rpt_cur_in   = '0;
      if (pop) begin
         case (head_entry.op)
            OP_SPEED_CMD: begin
               requested_in = head_entry.command_erpm;
               if (head_entry.command_erpm == '0) begin
                  blocked_in = 1'b0;
               end
               emit       = 1'b1;
               tx_erpm_in = blocked_in ? 32'd0 : head_entry.command_erpm;
            end
            OP_FRAME: begin
               if (stall_hit) begin
                  blocked_in  = 1'b1;
                  meas_rpm_in = '0;
                  meas_cur_in = '0;
                  emit        = 1'b1;
               end else begin
                  meas_rpm_in = signed_rpm;
                  meas_cur_in = head_entry.current;
               end
            end
            OP_TICK: begin
               timer_in = timer_next;
               if (timer_next >= cfg.report_interval_ms) begin
                  timer_in   = '0;
                  emit       = 1'b1;
                  kind_in    = RESULT_REPORT;
                  tx_id_in   = '0;
                  rpt_rpm_in = meas_rpm_ff;
                  rpt_cur_in = meas_cur_ff;
                  if (blocked_ff) begin
                     status_in = STATUS_BLOCKED;
                  end else if (!requested_ff[31] && (requested_ff != '0)) begin
                     status_in = STATUS_RUNNING;
                  end else begin
                     status_in = STATUS_IDLE;
                  end
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   // Load a new result when one is made, drop the old one once taken
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         requested_ff <= '0;
         blocked_ff   <= 1'b0;
         meas_rpm_ff  <= '0;
         meas_cur_ff  <= '0;
         timer_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         requested_ff <= requested_in;
         blocked_ff   <= blocked_in;
         meas_rpm_ff  <= meas_rpm_in;
         meas_cur_ff  <= meas_cur_in;
         timer_ff     <= timer_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         kind_ff    <= kind_in;
         tx_id_ff   <= tx_id_in;
         tx_erpm_ff <= tx_erpm_in;
         status_ff  <= status_in;
         rpt_rpm_ff <= rpt_rpm_in;
         rpt_cur_ff <= rpt_cur_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_tx_identifier  = tx_id_ff;
   assign rsp_tx_erpm        = $signed(tx_erpm_ff);
   assign rsp_cutter_status  = status_ff;
   assign rsp_report_rpm     = $signed(rpt_rpm_ff);
   assign rsp_report_current = $signed(rpt_cur_ff);

endmodule

// File: rtl/cutter_stall_guard_core.sv
// Top level of the cutter stall guard: register file, front end, queue, back end.
// Depends on csg_pkg, csg_front, csg_queue and csg_back.
//
// Stall guard for a CAN-driven blade motor. Speed commands, received frames
// and millisecond ticks enter on the req_ channel; set-speed frames and
// status reports leave on the rsp_ channel. One transaction is accepted per
// cycle while req_stall is low; a transaction that produces a result goes
// to rsp_ through two front stages (speed magnitude, then a 32x32 reciprocal
// multiply for ERPM/10), a pass through the four-entry queue, and the back
// end that updates the guard state and loads the output register.
// Frames from other nodes or of other kinds, and operation code 3, are
// dropped at the front. req_stall rises when the queue plus the front stages
// hold four transactions. The user must write registers through csr_ only
// while the block is idle, which it does not enforce; csr_ready is always high.
module cutter_stall_guard_core import csg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_command_erpm,
   input  logic [28:0]        req_frame_identifier,
   input  logic [31:0]        req_frame_speed_bytes,
   input  logic [15:0]        req_frame_current_bytes,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic [28:0]        rsp_tx_identifier,
   output logic signed [31:0] rsp_tx_erpm,
   output logic [1:0]         rsp_cutter_status,
   output logic signed [28:0] rsp_report_rpm,
   output logic signed [15:0] rsp_report_current
);

   csg_cfg_type   cfg_ff, cfg_in;
   csg_qstat_type q_stat;
   csg_entry_type push_entry;
   csg_entry_type head_entry;
   logic          push_valid;
   logic          pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_MOTOR_NODE_ID:       cfg_in.motor_node_id       = csr_data[7:0];
            REG_STALL_COMMAND_FLOOR: cfg_in.stall_command_floor = csr_data[30:0];
            REG_STALL_SPEED_LIMIT:   cfg_in.stall_speed_limit   = csr_data[30:0];
            REG_STALL_CURRENT_LIMIT: cfg_in.stall_current_limit = csr_data[14:0];
            REG_REPORT_INTERVAL_MS:  cfg_in.report_interval_ms  = csr_data[15:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motor_node_id       <= RESET_MOTOR_NODE_ID;
         cfg_ff.stall_command_floor <= RESET_STALL_COMMAND_FLOOR;
         cfg_ff.stall_speed_limit   <= RESET_STALL_SPEED_LIMIT;
         cfg_ff.stall_current_limit <= RESET_STALL_CURRENT_LIMIT;
         cfg_ff.report_interval_ms  <= RESET_REPORT_INTERVAL_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   csg_front u_front (
      .clock                   (clock),
      .reset                   (reset),
      .cfg                     (cfg_ff),
      .q_stat                  (q_stat),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_operation           (req_operation),
      .req_command_erpm        (req_command_erpm),
      .req_frame_identifier    (req_frame_identifier),
      .req_frame_speed_bytes   (req_frame_speed_bytes),
      .req_frame_current_bytes (req_frame_current_bytes),
      .push_valid              (push_valid),
      .push_entry              (push_entry)
   );

   csg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_stat     (q_stat)
   );

   csg_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_stat             (q_stat),
      .head_entry         (head_entry),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_tx_identifier  (rsp_tx_identifier),
      .rsp_tx_erpm        (rsp_tx_erpm),
      .rsp_cutter_status  (rsp_cutter_status),
      .rsp_report_rpm     (rsp_report_rpm),
      .rsp_report_current (rsp_report_current)
   );

   // The slot reservation in the front must keep the queue from overflowing
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && q_stat.full))
      else $error("queue push while full");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_report_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == RESULT_REPORT))
         |-> (rsp_tx_identifier == '0) && (rsp_tx_erpm == '0))
      else $error("status report carries frame fields");

   a_frame_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == RESULT_SET_SPEED))
         |-> (rsp_tx_identifier[15:8] == PKT_SET_RPM)
             && (rsp_cutter_status == STATUS_IDLE)
             && (rsp_report_rpm == '0) && (rsp_report_current == '0))
      else $error("set-speed frame carries report fields");

endmodule
